/* hdl/adsr_envelope_gain_core_assert.svh */
// assertion macros for the adsr envelope gain core
// expects clock and reset signals in the scope of each use
`ifndef ADSR_ENVELOPE_GAIN_CORE_ASSERT_SVH
`define ADSR_ENVELOPE_GAIN_CORE_ASSERT_SVH
`ifndef SYNTH
`define ADSR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adsr assertion failed");
`define ADSR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adsr assertion failed");
`else
`define ADSR_ASSERT_IMPL(lbl, ante, cons)
`define ADSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/adsr_pkg.sv */
// shared types and constants for the adsr envelope gain core
// no dependencies
`timescale 1ns / 1ps
package adsr_pkg;

   localparam int TIME_W     = 32;
   localparam int LEN_W      = 16;
   localparam int LVL_W      = 8;
   localparam int RECIP_W    = 25;
   localparam int FRAC_SHIFT = 24;
   localparam int LV16_W     = 16;

   typedef enum logic [1:0] {
      OP_SAMPLE   = 2'd0,
      OP_NOTE_ON  = 2'd1,
      OP_NOTE_OFF = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      PH_ATTACK  = 3'd0,
      PH_DECAY   = 3'd1,
      PH_SUSTAIN = 3'd2,
      PH_RELEASE = 3'd3,
      PH_OFF     = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      REG_ATTACK_LEN     = 3'd0,
      REG_DECAY_LEN      = 3'd1,
      REG_SUSTAIN_LEVEL  = 3'd2,
      REG_RELEASE_LEN    = 3'd3,
      REG_ATTACK_RECIP   = 3'd4,
      REG_DECAY_RECIP    = 3'd5,
      REG_RELEASE_RECIP  = 3'd6,
      REG_CHANNEL_VOLUME = 3'd7
   } reg_idx_type;

   // which formula produces the level
   typedef enum logic [2:0] {
      SEG_ATTACK,
      SEG_DECAY,
      SEG_SUSTAIN,
      SEG_RELEASE,
      SEG_FULL,
      SEG_ZERO
   } seg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RAMP,
      ST_GAIN,
      ST_OUT
   } st_type;

   typedef struct packed {
      logic [LEN_W-1:0]   attack_len;
      logic [LEN_W-1:0]   decay_len;
      logic [LVL_W-1:0]   sustain_level;
      logic [LEN_W-1:0]   release_len;
      logic [RECIP_W-1:0] attack_recip;
      logic [RECIP_W-1:0] decay_recip;
      logic [RECIP_W-1:0] release_recip;
      logic [LVL_W-1:0]   channel_volume;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             release_done;
      phase_type        phase_out;
      logic [LVL_W-1:0] gain;
   } rsp_item_type;

endpackage

/* hdl/adsr_mul.sv */
// shared 32 x 32 multiplier, low word of the product, registered
// depends on adsr_pkg
`timescale 1ns / 1ps
module adsr_mul
   import adsr_pkg::*;
(
   input  logic              clock,
   input  mul_req_type       req,
   output logic [TIME_W-1:0] p
);

   logic [TIME_W-1:0] p_ff;
   logic [TIME_W-1:0] p_in;

   // wraps modulo 2^32
   assign p_in = req.a * req.b;

   always_ff @(posedge clock) begin
      if (req.en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

/* hdl/adsr_ctl.sv */
// envelope sequencer: note state, phase decisions and multiplier operand steering
// depends on adsr_pkg, adsr_envelope_gain_core_assert.svh
`timescale 1ns / 1ps
`include "adsr_envelope_gain_core_assert.svh"
module adsr_ctl
   import adsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              start,
   input  logic [1:0]        op,
   input  logic [TIME_W-1:0] now,
   input  logic              slot_free,
   input  logic [TIME_W-1:0] mul_p,
   output logic              ready,
   output mul_req_type       mul_req,
   output logic              res_valid,
   output rsp_item_type      res
);

   st_type            state_ff, state_in;
   phase_type         phase_ff, phase_in;
   seg_type           seg_ff, seg_in;
   logic              done_ff, done_in;
   logic [TIME_W-1:0] start_stamp_ff, start_stamp_in;
   logic [TIME_W-1:0] release_stamp_ff, release_stamp_in;
   logic [TIME_W-1:0] now_ff, now_in;

   logic [TIME_W-1:0] t_el, u_el, alen32, rlen32, vol32, sus32, ad_sum;
   logic [LVL_W-1:0]  ramp;
   logic [LV16_W-1:0] lv16;
   logic              lv_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         phase_ff         <= PH_OFF;
         start_stamp_ff   <= '0;
         release_stamp_ff <= '0;
      end else begin
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         start_stamp_ff   <= start_stamp_in;
         release_stamp_ff <= release_stamp_in;
      end
      seg_ff  <= seg_in;
      done_ff <= done_in;
      now_ff  <= now_in;
   end

   assign t_el   = now_ff - start_stamp_ff;
   assign u_el   = now_ff - release_stamp_ff;
   assign alen32 = TIME_W'(cfg.attack_len);
   assign rlen32 = TIME_W'(cfg.release_len);
   assign vol32  = TIME_W'(cfg.channel_volume);
   assign sus32  = TIME_W'(cfg.sustain_level);
   assign ad_sum = alen32 + TIME_W'(cfg.decay_len);
   assign ramp   = mul_p[TIME_W-1:FRAC_SHIFT];

   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      seg_in           = seg_ff;
      done_in          = done_ff;
      start_stamp_in   = start_stamp_ff;
      release_stamp_in = release_stamp_ff;
      now_in           = now_ff;
      mul_req          = '0;
      res_valid        = 1'b0;
      ready            = 1'b0;
      lv16             = '0;
      lv_pos           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               now_in  = now;
               done_in = 1'b0;
               case (op_type'(op))
                  OP_NOTE_ON: begin
                     start_stamp_in = now;
                     phase_in       = PH_ATTACK;
                  end
                  OP_NOTE_OFF: begin
                     release_stamp_in = now;
                     phase_in         = PH_RELEASE;
                  end
                  default: ;
               endcase
               state_in = ST_SETUP;
            end
         end
         // pick the segment, first multiply: scale times elapsed or remaining span
         ST_SETUP: begin
            mul_req.en = 1'b1;
            case (phase_ff)
               PH_ATTACK, PH_DECAY, PH_SUSTAIN: begin
                  if (t_el < alen32) begin
                     seg_in    = SEG_ATTACK;
                     mul_req.a = t_el;
                     mul_req.b = vol32;
                  end else if (t_el < ad_sum) begin
                     seg_in    = SEG_DECAY;
                     phase_in  = PH_DECAY;
                     mul_req.a = t_el - alen32;
                     mul_req.b = vol32 - sus32;
                  end else begin
                     seg_in   = SEG_SUSTAIN;
                     phase_in = PH_SUSTAIN;
                  end
               end
               PH_RELEASE: begin
                  if (u_el < rlen32) begin
                     seg_in    = SEG_RELEASE;
                     mul_req.a = rlen32 - u_el;
                     mul_req.b = sus32;
                  end else begin
                     seg_in   = SEG_ZERO;
                     phase_in = PH_OFF;
                     done_in  = 1'b1;
                  end
               end
               default: begin
                  seg_in = SEG_FULL;
               end
            endcase
            state_in = ST_RAMP;
         end
         // second multiply: times the 2^24-scaled reciprocal
         ST_RAMP: begin
            mul_req.en = 1'b1;
            mul_req.a  = mul_p;
            case (seg_ff)
               SEG_ATTACK:  mul_req.b = TIME_W'(cfg.attack_recip);
               SEG_DECAY:   mul_req.b = TIME_W'(cfg.decay_recip);
               SEG_RELEASE: mul_req.b = TIME_W'(cfg.release_recip);
               default:     mul_req.b = '0;
            endcase
            state_in = ST_GAIN;
         end
         // level as 16-bit two's complement, third multiply: volume times level
         ST_GAIN: begin
            case (seg_ff)
               SEG_ATTACK, SEG_RELEASE: lv16 = LV16_W'(ramp);
               SEG_DECAY:   lv16 = LV16_W'(cfg.channel_volume) - LV16_W'(ramp);
               SEG_SUSTAIN: lv16 = LV16_W'(cfg.sustain_level);
               SEG_FULL:    lv16 = LV16_W'(cfg.channel_volume);
               default:     lv16 = '0;
            endcase
            lv_pos     = (lv16 != '0) && !lv16[LV16_W-1];
            mul_req.en = 1'b1;
            mul_req.a  = lv_pos ? TIME_W'(lv16) : '0;
            mul_req.b  = vol32;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.gain         = mul_p[2*LVL_W-1:LVL_W];
   assign res.phase_out    = phase_ff;
   assign res.release_done = done_ff;

   `ADSR_ASSERT_NEXT(a_accept_setup, start && ready, state_ff == ST_SETUP)
   `ADSR_ASSERT_IMPL(a_done_off, res_valid && res.release_done, res.phase_out == PH_OFF)
   `ADSR_ASSERT_NEXT(a_out_hold, (state_ff == ST_OUT) && !slot_free,
                     (state_ff == ST_OUT) && $stable(mul_p))

endmodule

/* hdl/adsr_envelope_gain_core.sv */
// top level of the adsr envelope gain core: config registers, result register
// depends on adsr_pkg, adsr_ctl, adsr_mul, adsr_envelope_gain_core_assert.svh
`timescale 1ns / 1ps
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tuser: op[1:0]; tdata: now[31:0]
//  rsp      out  rsp_tvalid/tready    tdata: gain[7:0] phase_out[10:8] release_done[11]
//  csr      in   csr_we               csr_addr[2:0], csr_wdata[24:0]
//
//  each item runs from accept to result register through the setup, ramp, gain and output steps:
//  three passes through the one shared 32 x 32 multiplier, the output step and the idle step
//  synchronous active-high reset: phase off, stamps and config registers zero
//  req_tready is high only while the sequencer is idle; an item may be taken
//  while the previous result still waits in the output register
//  a stalled result holds the sequencer in its last step until the slot frees
//
`include "adsr_envelope_gain_core_assert.svh"
module adsr_envelope_gain_core
   import adsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // now[31:0]
   input  logic [1:0]   req_tuser,   // op[1:0]
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // gain[7:0], phase_out[10:8], release_done[11], zero
   // register writes
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [24:0]  csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic              start;
   logic              slot_free;
   logic              ctl_ready;
   logic              res_valid;
   rsp_item_type      res;
   mul_req_type       mul_req;
   logic [TIME_W-1:0] mul_p;

   // config register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_idx_type'(csr_addr))
            REG_ATTACK_LEN:     cfg_in.attack_len     = csr_wdata[LEN_W-1:0];
            REG_DECAY_LEN:      cfg_in.decay_len      = csr_wdata[LEN_W-1:0];
            REG_SUSTAIN_LEVEL:  cfg_in.sustain_level  = csr_wdata[LVL_W-1:0];
            REG_RELEASE_LEN:    cfg_in.release_len    = csr_wdata[LEN_W-1:0];
            REG_ATTACK_RECIP:   cfg_in.attack_recip   = csr_wdata[RECIP_W-1:0];
            REG_DECAY_RECIP:    cfg_in.decay_recip    = csr_wdata[RECIP_W-1:0];
            REG_RELEASE_RECIP:  cfg_in.release_recip  = csr_wdata[RECIP_W-1:0];
            REG_CHANNEL_VOLUME: cfg_in.channel_volume = csr_wdata[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   // one-deep result register; refills in the cycle it drains
   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);
   assign rsp_item_in  = res_valid ? res : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign req_tready = ctl_ready;
   assign start      = req_tvalid && ctl_ready;

   adsr_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (start),
      .op        (req_tuser),
      .now       (req_tdata),
      .slot_free (slot_free),
      .mul_p     (mul_p),
      .ready     (ctl_ready),
      .mul_req   (mul_req),
      .res_valid (res_valid),
      .res       (res)
   );

   adsr_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .p     (mul_p)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_item_ff.release_done, rsp_item_ff.phase_out,
                        rsp_item_ff.gain};

   `ADSR_ASSERT_IMPL(a_no_overwrite, res_valid, !rsp_valid_ff || rsp_tready)
   `ADSR_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `ADSR_ASSERT_NEXT(a_vol_write, csr_we && (csr_addr == REG_CHANNEL_VOLUME),
                     cfg_ff.channel_volume == $past(csr_wdata[7:0]))

endmodule

/* bench/tb_top.sv */
// self-checking bench for adsr_envelope_gain_core: directed then random items
// depends on adsr_pkg and the core rtl; predicts each result with an in-bench envelope model
`timescale 1ns / 1ps
module tb_top;
   import adsr_pkg::*;

   // op 3 has no name in the package, it behaves like a sample
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [24:0] RECIP_ONE = 25'h100_0000;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] now;
   } env_req_type;

   // dut ports, every input known from time zero
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;   // now[31:0]
   logic [1:0]   req_tuser = '0;   // op[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [15:0]  rsp_tdata;       // gain[7:0], phase_out[10:8], release_done[11], zero pad
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [24:0]  csr_wdata = '0;

   // bench-side copy of the config registers
   logic [15:0] env_attack_len = '0;
   logic [15:0] env_decay_len = '0;
   logic [7:0]  env_sustain = '0;
   logic [15:0] env_release_len = '0;
   logic [24:0] env_attack_recip = '0;
   logic [24:0] env_decay_recip = '0;
   logic [24:0] env_release_recip = '0;
   logic [7:0]  env_volume = '0;

   // bench-side copy of the envelope state, matches reset values
   logic [31:0] env_start_stamp = '0;
   logic [31:0] env_release_stamp = '0;
   phase_type   env_phase = PH_OFF;

   env_req_type  pending_items[$];
   rsp_item_type expected_rsp[$];
   rsp_item_type next_rsp;

   int  error_count = 0;
   int  cycle_count = 0;
   int  item_count = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   bit  req_fired = 1'b0;
   bit  idle_on = 1'b1;
   bit  quiet = 1'b0;

   adsr_envelope_gain_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // envelope model: applies the op, then computes the level and the gain
   // all products are kept at 32 bits so they wrap the same way the block does
   function automatic rsp_item_type envelope_predict(logic [1:0] op, logic [31:0] now);
      rsp_item_type r;
      logic [31:0] vol, sus, t, u, prod, level, gain32;
      logic [15:0] lv16;
      logic        done;
      vol = {24'd0, env_volume};
      sus = {24'd0, env_sustain};
      done = 1'b0;
      if (op == OP_NOTE_ON) begin
         env_start_stamp = now;
         env_phase = PH_ATTACK;
      end else if (op == OP_NOTE_OFF) begin
         env_release_stamp = now;
         env_phase = PH_RELEASE;
      end
      if (env_phase != PH_RELEASE && env_phase != PH_OFF) begin
         t = now - env_start_stamp;
         if (t < {16'd0, env_attack_len}) begin
            // also taken when time wrapped back while in decay or sustain;
            // the phase is left where it is
            prod = vol * t * {7'd0, env_attack_recip};
            level = prod >> 24;
         end else if (t < {16'd0, env_attack_len} + {16'd0, env_decay_len}) begin
            env_phase = PH_DECAY;
            // wraps when sustain sits above the volume
            prod = (vol - sus) * (t - {16'd0, env_attack_len}) * {7'd0, env_decay_recip};
            level = vol - (prod >> 24);
         end else begin
            env_phase = PH_SUSTAIN;
            level = sus;
         end
      end else if (env_phase == PH_RELEASE) begin
         u = now - env_release_stamp;
         if (u < {16'd0, env_release_len}) begin
            prod = ({16'd0, env_release_len} - u) * sus * {7'd0, env_release_recip};
            level = prod >> 24;
         end else begin
            env_phase = PH_OFF;
            done = 1'b1;
            level = '0;
         end
      end else begin
         // off passes the full volume
         level = vol;
      end
      // level read as 16-bit signed, only 1..32767 counts as positive
      lv16 = level[15:0];
      gain32 = '0;
      if (lv16 != 16'd0 && lv16 < 16'h8000)
         gain32 = (vol * {16'd0, lv16}) >> 8;
      r.gain = gain32[7:0];
      r.phase_out = env_phase;
      r.release_done = done;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   task automatic check_result(logic [15:0] data);
      rsp_item_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch("result with no item outstanding", 32'(data), 32'd0);
      end else begin
         want = expected_rsp.pop_front();
         if (data[7:0] !== want.gain)
            report_mismatch("gain", 32'(data[7:0]), 32'(want.gain));
         if (data[10:8] !== want.phase_out)
            report_mismatch("phase_out", 32'(data[10:8]), 32'(want.phase_out));
         if (data[11] !== want.release_done)
            report_mismatch("release_done", 32'(data[11]), 32'(want.release_done));
         if (data[15:12] !== 4'd0)
            report_mismatch("pad bits", 32'(data[15:12]), 32'd0);
      end
   endtask

   // monitor: results are checked before new items are predicted, the
   // result of a same-edge item cannot be out yet
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            check_result(rsp_tdata);
         if (req_tvalid && req_tready) begin
            next_rsp = envelope_predict(req_tuser, req_tdata);
            expected_rsp.push_back(next_rsp);
            void'(pending_items.pop_front());
            req_fired = 1'b1;
         end
      end
   end

   // request driver: valid only drops between items, never while one is offered
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         req_fired = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            // idle burst
            req_gap = $urandom_range(0, 7);
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_items[0].now;
            req_tuser <= pending_items[0].op;
         end
      end
   end

   // result side back-pressure, same burst shape
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && !quiet && $urandom_range(0, 6) == 0) begin
         rsp_gap = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic push_item(logic [1:0] op, logic [31:0] now);
      env_req_type it;
      it.op = op;
      it.now = now;
      pending_items.push_back(it);
      item_count++;
   endtask

   // register write, model copy follows at once since nothing is in flight
   task automatic write_reg(reg_idx_type idx, logic [24:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         REG_ATTACK_LEN:     env_attack_len = val[15:0];
         REG_DECAY_LEN:      env_decay_len = val[15:0];
         REG_SUSTAIN_LEVEL:  env_sustain = val[7:0];
         REG_RELEASE_LEN:    env_release_len = val[15:0];
         REG_ATTACK_RECIP:   env_attack_recip = val;
         REG_DECAY_RECIP:    env_decay_recip = val;
         REG_RELEASE_RECIP:  env_release_recip = val;
         REG_CHANNEL_VOLUME: env_volume = val[7:0];
         default: ;
      endcase
   endtask

   task automatic set_envelope(int alen, int dlen, int sus, int rlen,
                               int arec, int drec, int rrec, int vol);
      write_reg(REG_ATTACK_LEN, 25'(alen));
      write_reg(REG_DECAY_LEN, 25'(dlen));
      write_reg(REG_SUSTAIN_LEVEL, 25'(sus));
      write_reg(REG_RELEASE_LEN, 25'(rlen));
      write_reg(REG_ATTACK_RECIP, 25'(arec));
      write_reg(REG_DECAY_RECIP, 25'(drec));
      write_reg(REG_RELEASE_RECIP, 25'(rrec));
      write_reg(REG_CHANNEL_VOLUME, 25'(vol));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // block is idle once every item has come back as a result
   task automatic drain();
      while (pending_items.size() != 0 || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // reciprocal as software would set it, random when the segment is empty
   function automatic int recip_for(int len);
      if (len == 0)
         return $urandom_range(0, RECIP_ONE);
      return RECIP_ONE / len;
   endfunction

   function automatic int pick_len();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 65535);
      return $urandom_range(0, 400);
   endfunction

   function automatic logic [1:0] sample_op();
      return ($urandom_range(0, 15) == 0) ? OP_SPARE : OP_SAMPLE;
   endfunction

   // one note: on, samples walking through attack, decay and sustain,
   // mostly an off and samples through the release tail
   task automatic add_note();
      logic [31:0] tnow;
      int step, rstep, n;
      tnow = $urandom;
      push_item(OP_NOTE_ON, tnow);
      step = (int'(env_attack_len) + int'(env_decay_len)) / 6 + 1;
      n = $urandom_range(3, 10);
      repeat (n) begin
         tnow += $urandom_range(0, step);
         push_item(sample_op(), tnow);
      end
      // time stepping back lands in the attack formula from a later phase
      if ($urandom_range(0, 7) == 0)
         push_item(OP_SAMPLE, tnow - $urandom_range(0, step * 6));
      if ($urandom_range(0, 7) != 0) begin
         tnow += $urandom_range(0, step);
         push_item(OP_NOTE_OFF, tnow);
         rstep = int'(env_release_len) / 4 + 1;
         n = $urandom_range(2, 8);
         repeat (n) begin
            tnow += $urandom_range(0, rstep);
            push_item(sample_op(), tnow);
         end
      end
   endtask

   task automatic add_noise();
      push_item(2'($urandom_range(0, 3)), $urandom);
   endtask

   initial begin
      int alen, dlen, rlen, sus, vol;
      int phase_items;
      logic [31:0] base;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: off with zero volume
      push_item(OP_SAMPLE, 32'd0);
      drain();

      // a plain envelope, note-on close to the top so time wraps in attack
      set_envelope(100, 100, 128, 100, 167772, 167772, 167772, 255);
      push_item(OP_SAMPLE, 32'd0);
      push_item(OP_SPARE, 32'hFFFF_FFFF);
      push_item(OP_NOTE_OFF, 32'd10);        // note-off straight from off
      push_item(OP_SAMPLE, 32'd200);         // release ends here
      push_item(OP_SAMPLE, 32'd300);
      base = 32'hFFFF_FFF0;
      push_item(OP_NOTE_ON, base);
      push_item(OP_SAMPLE, base + 32'd50);
      push_item(OP_SAMPLE, base + 32'd150);
      push_item(OP_SAMPLE, base + 32'd300);
      push_item(OP_SAMPLE, base + 32'd5);    // time back inside attack while in sustain
      push_item(OP_NOTE_OFF, base + 32'd400);
      push_item(OP_SAMPLE, base + 32'd450);
      push_item(OP_SAMPLE, base + 32'd500);
      drain();

      // zero durations skip every segment
      set_envelope(0, 0, 200, 0, 0, 0, 0, 255);
      push_item(OP_NOTE_ON, 32'd5);
      push_item(OP_SAMPLE, 32'd5);
      push_item(OP_NOTE_OFF, 32'd6);
      drain();

      // sustain above volume, longest release with a reciprocal of 256
      set_envelope(0, 1000, 255, 65535, RECIP_ONE, 16777, 256, 100);
      push_item(OP_NOTE_ON, 32'd0);
      push_item(OP_SAMPLE, 32'd500);
      push_item(OP_SAMPLE, 32'd1000);
      push_item(OP_NOTE_OFF, 32'd2000);
      push_item(OP_SAMPLE, 32'd2000 + 32'd65534);
      drain();

      // random phases, each with its own register setting
      for (int p = 0; p < 8; p++) begin
         idle_on = (p % 3 != 2);
         quiet = (p == 7);
         case (p)
            1: set_envelope(65535, 65535, 255, 65535, RECIP_ONE, RECIP_ONE, RECIP_ONE, 255);
            5: set_envelope(0, 0, 0, 0, 0, 0, 0, 255);
            2, 6: set_envelope($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 255), $urandom_range(0, 65535),
                               $urandom_range(0, RECIP_ONE), $urandom_range(0, RECIP_ONE),
                               $urandom_range(0, RECIP_ONE), $urandom_range(0, 255));
            default: begin
               alen = pick_len();
               dlen = pick_len();
               rlen = pick_len();
               vol = $urandom_range(0, 255);
               // p 3 puts sustain at or above volume
               sus = (p == 3) ? $urandom_range(vol, 255) : $urandom_range(0, vol);
               set_envelope(alen, dlen, sus, rlen, recip_for(alen), recip_for(dlen),
                            recip_for(rlen), vol);
            end
         endcase
         phase_items = item_count;
         while (item_count - phase_items < 150) begin
            if ($urandom_range(0, 4) == 0)
               add_noise();
            else
               add_note();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* adsr_envelope_gain_core.f */
+incdir+hdl
hdl/adsr_pkg.sv
hdl/adsr_mul.sv
hdl/adsr_ctl.sv
hdl/adsr_envelope_gain_core.sv
bench/tb_top.sv
